>>> rtl/mac_pkg.sv
// Shared types and constants for the multiply-accumulate unit.
// No dependencies; imported by mac_check and multiply_accumulate_unit.
package mac_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned IDX_W  = 4;
   localparam int unsigned MODE_W = 3;

   // Register number of the program counter, never a legal operand here
   localparam logic [IDX_W-1:0] PC_INDEX = 4'd15;

   // Operation codes; the two highest codes carry no operation
   typedef enum logic [MODE_W-1:0] {
      MODE_MUL   = 3'd0,
      MODE_MLA   = 3'd1,
      MODE_UMULL = 3'd2,
      MODE_UMLAL = 3'd3,
      MODE_SMULL = 3'd4,
      MODE_SMLAL = 3'd5
   } mode_type;

   // Decoded control for one transaction
   typedef struct packed {
      logic unpredictable;
      logic is_long;
      logic accumulate;
      logic signed_mul;
   } mac_ctrl_type;

endpackage

>>> rtl/multiply_accumulate_unit.sv
// Top level of the multiply-accumulate unit: input, product and result stages.
// Depends on mac_pkg and mac_check.
//
//   Channel   Direction   Handshake               Carries
//   req_      in          req_valid / req_ready   one decoded multiply instruction
//   rsp_      out         rsp_valid / rsp_ready   result words, write enables, N/Z
//
// Three registers: input, product (the 33x33 multiplier) and result (the
// 64-bit accumulate add). A request passes through them in order before its
// response is presented. One transaction is accepted every cycle while the
// response side keeps up. Reset clears the stage valid bits only. A stalled
// response holds its stage, the stages behind it keep filling, and req_ready
// drops once all three stages hold a transaction.
module multiply_accumulate_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mac_pkg::MODE_W-1:0]    req_mode,
   input  logic                          req_set_flags,
   input  logic [mac_pkg::WORD_W-1:0]    req_op_m,
   input  logic [mac_pkg::WORD_W-1:0]    req_op_s,
   input  logic [mac_pkg::WORD_W-1:0]    req_acc_lo,
   input  logic [mac_pkg::WORD_W-1:0]    req_acc_hi,
   input  logic [mac_pkg::IDX_W-1:0]     req_idx_m,
   input  logic [mac_pkg::IDX_W-1:0]     req_idx_s,
   input  logic [mac_pkg::IDX_W-1:0]     req_idx_n,
   input  logic [mac_pkg::IDX_W-1:0]     req_idx_dst_lo,
   input  logic [mac_pkg::IDX_W-1:0]     req_idx_dst_hi,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mac_pkg::WORD_W-1:0]    rsp_result_lo,
   output logic [mac_pkg::WORD_W-1:0]    rsp_result_hi,
   output logic                          rsp_write_lo,
   output logic                          rsp_write_hi,
   output logic                          rsp_flag_n,
   output logic                          rsp_flag_z,
   output logic                          rsp_flags_write,
   output logic                          rsp_unpredictable
);
   import mac_pkg::*;

   localparam int unsigned DWORD_W = 2 * WORD_W;

   // Stage enables
   logic s1_open;
   logic s2_open;
   logic out_open;

   // Input stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [MODE_W-1:0]    s1_mode_ff;
   logic                 s1_set_flags_ff;
   logic [WORD_W-1:0]    s1_op_m_ff, s1_op_s_ff, s1_acc_lo_ff, s1_acc_hi_ff;
   logic [IDX_W-1:0]     s1_idx_m_ff, s1_idx_s_ff, s1_idx_n_ff;
   logic [IDX_W-1:0]     s1_idx_dst_lo_ff, s1_idx_dst_hi_ff;

   // Product stage
   logic                 s2_valid_ff, s2_valid_in;
   mac_ctrl_type         s1_ctrl;
   mac_ctrl_type         s2_ctrl_ff;
   logic                 s2_set_flags_ff;
   logic [DWORD_W-1:0]   s2_prod_ff, s2_prod_in;
   logic [DWORD_W-1:0]   s2_acc_ff, s2_acc_in;

   logic signed [WORD_W:0]     mul_a, mul_b;
   logic signed [2*WORD_W+1:0] mul_full;

   // Result stage
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_result_lo_ff, rsp_result_lo_in;
   logic [WORD_W-1:0]    rsp_result_hi_ff, rsp_result_hi_in;
   logic                 rsp_write_lo_ff, rsp_write_lo_in;
   logic                 rsp_write_hi_ff, rsp_write_hi_in;
   logic                 rsp_flag_n_ff, rsp_flag_n_in;
   logic                 rsp_flag_z_ff, rsp_flag_z_in;
   logic                 rsp_flags_write_ff, rsp_flags_write_in;
   logic                 rsp_unpredictable_ff, rsp_unpredictable_in;

   logic [DWORD_W-1:0]   sum;
   logic                 sum_n;
   logic                 sum_z;

   // Advance a stage when it is empty or its contents move on
   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign s2_open   = !s2_valid_ff || out_open;
   assign s1_open   = !s1_valid_ff || s2_open;
   assign req_ready = s1_open;

   assign s1_valid_in  = s1_open  ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_open  ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = out_open ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (req_valid && s1_open) begin
         s1_mode_ff       <= req_mode;
         s1_set_flags_ff  <= req_set_flags;
         s1_op_m_ff       <= req_op_m;
         s1_op_s_ff       <= req_op_s;
         s1_acc_lo_ff     <= req_acc_lo;
         s1_acc_hi_ff     <= req_acc_hi;
         s1_idx_m_ff      <= req_idx_m;
         s1_idx_s_ff      <= req_idx_s;
         s1_idx_n_ff      <= req_idx_n;
         s1_idx_dst_lo_ff <= req_idx_dst_lo;
         s1_idx_dst_hi_ff <= req_idx_dst_hi;
      end
   end

   // Decode and check register use
   mac_check u_check (
      .mode       (mode_type'(s1_mode_ff)),
      .idx_m      (s1_idx_m_ff),
      .idx_s      (s1_idx_s_ff),
      .idx_n      (s1_idx_n_ff),
      .idx_dst_lo (s1_idx_dst_lo_ff),
      .idx_dst_hi (s1_idx_dst_hi_ff),
      .ctrl       (s1_ctrl)
   );

   // Extend the factors by one bit so one signed multiplier serves both forms
   assign mul_a    = signed'({s1_ctrl.signed_mul & s1_op_m_ff[WORD_W-1], s1_op_m_ff});
   assign mul_b    = signed'({s1_ctrl.signed_mul & s1_op_s_ff[WORD_W-1], s1_op_s_ff});
   assign mul_full = mul_a * mul_b;

   // Select the addend: rn for the short form, rdhi:rdlo for the long one
   always_comb begin
      s2_prod_in = mul_full[DWORD_W-1:0];
      s2_acc_in  = '0;
      if (s1_ctrl.accumulate) begin
         s2_acc_in[WORD_W-1:0] = s1_acc_lo_ff;
         if (s1_ctrl.is_long) begin
            s2_acc_in[DWORD_W-1:WORD_W] = s1_acc_hi_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_open) begin
         s2_ctrl_ff      <= s1_ctrl;
         s2_set_flags_ff <= s1_set_flags_ff;
         s2_prod_ff      <= s2_prod_in;
         s2_acc_ff       <= s2_acc_in;
      end
   end

   // Accumulate and derive N and Z from the result width of the form
   assign sum   = s2_prod_ff + s2_acc_ff;
   assign sum_n = s2_ctrl_ff.is_long ? sum[DWORD_W-1] : sum[WORD_W-1];
   assign sum_z = s2_ctrl_ff.is_long ? (sum == '0) : (sum[WORD_W-1:0] == '0);

   // Drop every write when the register use is unpredictable
   always_comb begin
      rsp_result_lo_in     = '0;
      rsp_result_hi_in     = '0;
      rsp_write_lo_in      = 1'b0;
      rsp_write_hi_in      = 1'b0;
      rsp_flag_n_in        = 1'b0;
      rsp_flag_z_in        = 1'b0;
      rsp_flags_write_in   = 1'b0;
      rsp_unpredictable_in = s2_ctrl_ff.unpredictable;
      if (!s2_ctrl_ff.unpredictable) begin
         rsp_result_lo_in   = sum[WORD_W-1:0];
         rsp_write_lo_in    = 1'b1;
         rsp_write_hi_in    = s2_ctrl_ff.is_long;
         rsp_flag_n_in      = sum_n;
         rsp_flag_z_in      = sum_z;
         rsp_flags_write_in = s2_set_flags_ff;
         if (s2_ctrl_ff.is_long) begin
            rsp_result_hi_in = sum[DWORD_W-1:WORD_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && out_open) begin
         rsp_result_lo_ff     <= rsp_result_lo_in;
         rsp_result_hi_ff     <= rsp_result_hi_in;
         rsp_write_lo_ff      <= rsp_write_lo_in;
         rsp_write_hi_ff      <= rsp_write_hi_in;
         rsp_flag_n_ff        <= rsp_flag_n_in;
         rsp_flag_z_ff        <= rsp_flag_z_in;
         rsp_flags_write_ff   <= rsp_flags_write_in;
         rsp_unpredictable_ff <= rsp_unpredictable_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_lo     = rsp_result_lo_ff;
   assign rsp_result_hi     = rsp_result_hi_ff;
   assign rsp_write_lo      = rsp_write_lo_ff;
   assign rsp_write_hi      = rsp_write_hi_ff;
   assign rsp_flag_n        = rsp_flag_n_ff;
   assign rsp_flag_z        = rsp_flag_z_ff;
   assign rsp_flags_write   = rsp_flags_write_ff;
   assign rsp_unpredictable = rsp_unpredictable_ff;

   // An accepted request always occupies the input stage next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted transaction lost at input stage");

   // An unpredictable transaction writes nothing
   a_bad_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_unpredictable) |->
         (!rsp_write_lo && !rsp_write_hi && !rsp_flags_write &&
          rsp_result_lo == '0 && rsp_result_hi == '0))
      else $error("unpredictable transaction carries a write");

   // A high word write comes only with a low word write
   a_hi_needs_lo: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_hi) |-> rsp_write_lo)
      else $error("high word written without low word");

   // Short forms give a zero high word and N from bit 31
   a_short_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_lo && !rsp_write_hi) |->
         (rsp_result_hi == '0 && rsp_flag_n == rsp_result_lo[WORD_W-1]))
      else $error("short form result inconsistent");

   // Long forms derive N and Z from the full 64-bit result
   a_long_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_hi) |->
         (rsp_flag_n == rsp_result_hi[WORD_W-1] &&
          rsp_flag_z == (rsp_result_lo == '0 && rsp_result_hi == '0)))
      else $error("long form flags inconsistent");

endmodule

>>> rtl/mac_check.sv
// Operation decode and register-use check for the multiply-accumulate unit.
// Depends on mac_pkg for the operation codes and the control struct.
module mac_check (
   input  mac_pkg::mode_type              mode,
   input  logic [mac_pkg::IDX_W-1:0]      idx_m,
   input  logic [mac_pkg::IDX_W-1:0]      idx_s,
   input  logic [mac_pkg::IDX_W-1:0]      idx_n,
   input  logic [mac_pkg::IDX_W-1:0]      idx_dst_lo,
   input  logic [mac_pkg::IDX_W-1:0]      idx_dst_hi,
   output mac_pkg::mac_ctrl_type          ctrl
);
   import mac_pkg::*;

   logic short_bad;
   logic long_bad;

   // Short forms: no PC anywhere, rd must differ from rm
   assign short_bad = (idx_m == PC_INDEX) || (idx_s == PC_INDEX) ||
                      (idx_n == PC_INDEX) || (idx_dst_lo == PC_INDEX) ||
                      (idx_dst_lo == idx_m);

   // Long forms: no PC, rm, rdlo and rdhi all distinct
   assign long_bad = (idx_m == PC_INDEX) || (idx_s == PC_INDEX) ||
                     (idx_dst_lo == PC_INDEX) || (idx_dst_hi == PC_INDEX) ||
                     (idx_m == idx_dst_lo) || (idx_m == idx_dst_hi) ||
                     (idx_dst_lo == idx_dst_hi);

   // Decode the operation
   always_comb begin
      ctrl = '0;
      unique case (mode)
         MODE_MUL: begin
            ctrl.unpredictable = short_bad;
         end
         MODE_MLA: begin
            ctrl.unpredictable = short_bad;
            ctrl.accumulate    = 1'b1;
         end
         MODE_UMULL: begin
            ctrl.unpredictable = long_bad;
            ctrl.is_long       = 1'b1;
         end
         MODE_UMLAL: begin
            ctrl.unpredictable = long_bad;
            ctrl.is_long       = 1'b1;
            ctrl.accumulate    = 1'b1;
         end
         MODE_SMULL: begin
            ctrl.unpredictable = long_bad;
            ctrl.is_long       = 1'b1;
            ctrl.signed_mul    = 1'b1;
         end
         MODE_SMLAL: begin
            ctrl.unpredictable = long_bad;
            ctrl.is_long       = 1'b1;
            ctrl.accumulate    = 1'b1;
            ctrl.signed_mul    = 1'b1;
         end
         default: begin
            ctrl.unpredictable = 1'b1;
         end
      endcase
   end

endmodule

>>> verif/tb.sv
// Self-checking testbench for multiply_accumulate_unit: directed, random and back-pressure tests.
// Depends on rtl/mac_pkg.sv and rtl/multiply_accumulate_unit.sv.
// Results are checked in order against a built-in model of the multiply modes.
module tb;
   import mac_pkg::*;

   // Mode codes with no operation behind them
   localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;
   localparam int unsigned MAX_PRINTED = 30;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              set_flags;
      logic [WORD_W-1:0] op_m;
      logic [WORD_W-1:0] op_s;
      logic [WORD_W-1:0] acc_lo;
      logic [WORD_W-1:0] acc_hi;
      logic [IDX_W-1:0]  idx_m;
      logic [IDX_W-1:0]  idx_s;
      logic [IDX_W-1:0]  idx_n;
      logic [IDX_W-1:0]  idx_dst_lo;
      logic [IDX_W-1:0]  idx_dst_hi;
   } mul_insn_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_lo;
      logic [WORD_W-1:0] result_hi;
      logic              write_lo;
      logic              write_hi;
      logic              flag_n;
      logic              flag_z;
      logic              flags_write;
      logic              unpredictable;
   } mul_result_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [MODE_W-1:0] req_mode;
   logic              req_set_flags;
   logic [WORD_W-1:0] req_op_m;
   logic [WORD_W-1:0] req_op_s;
   logic [WORD_W-1:0] req_acc_lo;
   logic [WORD_W-1:0] req_acc_hi;
   logic [IDX_W-1:0]  req_idx_m;
   logic [IDX_W-1:0]  req_idx_s;
   logic [IDX_W-1:0]  req_idx_n;
   logic [IDX_W-1:0]  req_idx_dst_lo;
   logic [IDX_W-1:0]  req_idx_dst_hi;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [WORD_W-1:0] rsp_result_lo;
   logic [WORD_W-1:0] rsp_result_hi;
   logic              rsp_write_lo;
   logic              rsp_write_hi;
   logic              rsp_flag_n;
   logic              rsp_flag_z;
   logic              rsp_flags_write;
   logic              rsp_unpredictable;

   mul_result_type pending_results[$];
   int unsigned error_count;
   int unsigned insn_accepted;
   int unsigned results_checked;
   int unsigned unpredictable_seen;
   bit          sender_idle_on;
   bit          recv_idle_on;
   bit          recv_hold;
   int unsigned recv_gap_left;

   multiply_accumulate_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_set_flags     (req_set_flags),
      .req_op_m          (req_op_m),
      .req_op_s          (req_op_s),
      .req_acc_lo        (req_acc_lo),
      .req_acc_hi        (req_acc_hi),
      .req_idx_m         (req_idx_m),
      .req_idx_s         (req_idx_s),
      .req_idx_n         (req_idx_n),
      .req_idx_dst_lo    (req_idx_dst_lo),
      .req_idx_dst_hi    (req_idx_dst_hi),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_lo     (rsp_result_lo),
      .rsp_result_hi     (rsp_result_hi),
      .rsp_write_lo      (rsp_write_lo),
      .rsp_write_hi      (rsp_write_hi),
      .rsp_flag_n        (rsp_flag_n),
      .rsp_flag_z        (rsp_flag_z),
      .rsp_flags_write   (rsp_flags_write),
      .rsp_unpredictable (rsp_unpredictable)
   );

   // Free-running clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Compute the expected outcome of one multiply instruction
   function automatic mul_result_type predict_mac(input mul_insn_type c);
      mul_result_type r;
      logic        is_long;
      logic        bad;
      logic        sgn;
      logic [31:0] lo32;
      logic [63:0] wide_m;
      logic [63:0] wide_s;
      logic [63:0] prod;
      r       = '0;
      is_long = (c.mode >= MODE_UMULL);
      if (c.mode == MODE_RSVD6 || c.mode == MODE_RSVD7) begin
         bad = 1'b1;
      end else if (!is_long) begin
         bad = c.idx_m == PC_INDEX || c.idx_s == PC_INDEX || c.idx_n == PC_INDEX ||
               c.idx_dst_lo == PC_INDEX || c.idx_dst_lo == c.idx_m;
      end else begin
         bad = c.idx_m == PC_INDEX || c.idx_s == PC_INDEX || c.idx_dst_lo == PC_INDEX ||
               c.idx_dst_hi == PC_INDEX || c.idx_m == c.idx_dst_lo ||
               c.idx_m == c.idx_dst_hi || c.idx_dst_lo == c.idx_dst_hi;
      end
      // Unpredictable register use suppresses every write
      if (bad) begin
         r.unpredictable = 1'b1;
         return r;
      end
      if (!is_long) begin
         lo32 = c.op_m * c.op_s;
         if (c.mode == MODE_MLA)
            lo32 = lo32 + c.acc_lo;
         r.result_lo = lo32;
         r.flag_n    = lo32[31];
         r.flag_z    = (lo32 == '0);
      end else begin
         sgn    = (c.mode == MODE_SMULL || c.mode == MODE_SMLAL);
         wide_m = sgn ? {{32{c.op_m[31]}}, c.op_m} : {32'b0, c.op_m};
         wide_s = sgn ? {{32{c.op_s[31]}}, c.op_s} : {32'b0, c.op_s};
         prod   = wide_m * wide_s;
         if (c.mode == MODE_UMLAL || c.mode == MODE_SMLAL)
            prod = prod + {c.acc_hi, c.acc_lo};
         r.result_lo = prod[31:0];
         r.result_hi = prod[63:32];
         r.write_hi  = 1'b1;
         r.flag_n    = prod[63];
         r.flag_z    = (prod == '0);
      end
      r.write_lo    = 1'b1;
      r.flags_write = c.set_flags;
      return r;
   endfunction

   // Print one mismatch line, up to a cap, and count it
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("tb: mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
   endtask

   // Predict accepted requests and check each response against the oldest prediction
   always @(posedge clock) begin
      mul_insn_type   seen;
      mul_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected response", rsp_result_lo, '0);
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (rsp_unpredictable)
                  unpredictable_seen++;
               if (rsp_result_lo !== want.result_lo)
                  report_mismatch("result_lo", rsp_result_lo, want.result_lo);
               if (rsp_result_hi !== want.result_hi)
                  report_mismatch("result_hi", rsp_result_hi, want.result_hi);
               if (rsp_write_lo !== want.write_lo)
                  report_mismatch("write_lo", rsp_write_lo, want.write_lo);
               if (rsp_write_hi !== want.write_hi)
                  report_mismatch("write_hi", rsp_write_hi, want.write_hi);
               if (rsp_flag_n !== want.flag_n)
                  report_mismatch("flag_n", rsp_flag_n, want.flag_n);
               if (rsp_flag_z !== want.flag_z)
                  report_mismatch("flag_z", rsp_flag_z, want.flag_z);
               if (rsp_flags_write !== want.flags_write)
                  report_mismatch("flags_write", rsp_flags_write, want.flags_write);
               if (rsp_unpredictable !== want.unpredictable)
                  report_mismatch("unpredictable", rsp_unpredictable, want.unpredictable);
            end
         end
         if (req_valid && req_ready) begin
            seen = '{req_mode, req_set_flags, req_op_m, req_op_s, req_acc_lo, req_acc_hi,
                     req_idx_m, req_idx_s, req_idx_n, req_idx_dst_lo, req_idx_dst_hi};
            pending_results.push_back(predict_mac(seen));
            insn_accepted++;
         end
      end
   end

   // Drive response ready: long hold, random stall bursts, or always ready
   always @(posedge clock) begin
      if (recv_hold) begin
         rsp_ready <= 1'b0;
      end else if (recv_gap_left > 0) begin
         rsp_ready <= 1'b0;
         recv_gap_left <= recv_gap_left - 1;
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         recv_gap_left <= $urandom_range(0, 16);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offer one transaction, optionally after an idle burst, and hold it until accepted
   task automatic send_insn(input mul_insn_type c);
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= c.mode;
      req_set_flags  <= c.set_flags;
      req_op_m       <= c.op_m;
      req_op_s       <= c.op_s;
      req_acc_lo     <= c.acc_lo;
      req_acc_hi     <= c.acc_hi;
      req_idx_m      <= c.idx_m;
      req_idx_s      <= c.idx_s;
      req_idx_n      <= c.idx_n;
      req_idx_dst_lo <= c.idx_dst_lo;
      req_idx_dst_hi <= c.idx_dst_hi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted response has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Operand word biased toward the arithmetic corners
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'h0000_0001;
         5: return 32'h3FFF_FFFF;
         6: return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // Build a well-formed instruction: no PC in a used register, rdlo differs from rm, rdhi from both
   function automatic mul_insn_type rand_legal_insn();
      mul_insn_type c;
      c.mode       = MODE_W'($urandom_range(MODE_MUL, MODE_SMLAL));
      c.set_flags  = 1'($urandom_range(0, 1));
      c.op_m       = rand_word();
      c.op_s       = rand_word();
      c.acc_lo     = rand_word();
      c.acc_hi     = rand_word();
      c.idx_m      = IDX_W'($urandom_range(0, 14));
      c.idx_s      = IDX_W'($urandom_range(0, 14));
      c.idx_n      = IDX_W'($urandom_range(0, 14));
      c.idx_dst_lo = IDX_W'($urandom_range(0, 14));
      c.idx_dst_hi = IDX_W'($urandom_range(0, 14));
      while (c.idx_dst_lo == c.idx_m) c.idx_dst_lo = IDX_W'($urandom_range(0, 14));
      if (c.mode >= MODE_UMULL) begin
         while (c.idx_dst_hi == c.idx_m || c.idx_dst_hi == c.idx_dst_lo)
            c.idx_dst_hi = IDX_W'($urandom_range(0, 14));
         c.idx_n = IDX_W'($urandom_range(0, 15));
      end else begin
         c.idx_dst_hi = IDX_W'($urandom_range(0, 15));
      end
      return c;
   endfunction

   // Mostly well-formed, some with one register fault, a few pure noise
   function automatic mul_insn_type rand_insn();
      mul_insn_type c;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      c    = rand_legal_insn();
      if (pick >= 90) begin
         c.mode       = MODE_W'($urandom_range(0, 7));
         c.idx_m      = IDX_W'($urandom_range(0, 15));
         c.idx_s      = IDX_W'($urandom_range(0, 15));
         c.idx_n      = IDX_W'($urandom_range(0, 15));
         c.idx_dst_lo = IDX_W'($urandom_range(0, 15));
         c.idx_dst_hi = IDX_W'($urandom_range(0, 15));
         c.op_m       = $urandom;
         c.op_s       = $urandom;
      end else if (pick >= 75) begin
         case ($urandom_range(0, 7))
            0: c.idx_m      = PC_INDEX;
            1: c.idx_s      = PC_INDEX;
            2: c.idx_n      = PC_INDEX;
            3: c.idx_dst_lo = PC_INDEX;
            4: c.idx_dst_hi = PC_INDEX;
            5: c.idx_dst_lo = c.idx_m;
            6: c.idx_dst_hi = c.idx_m;
            default: c.idx_dst_hi = c.idx_dst_lo;
         endcase
      end
      return c;
   endfunction

   function automatic mul_insn_type make_insn(input logic [2:0] mode, input logic sf,
                                              input logic [31:0] m, input logic [31:0] s,
                                              input logic [31:0] alo, input logic [31:0] ahi,
                                              input logic [3:0] im, input logic [3:0] is,
                                              input logic [3:0] in_idx, input logic [3:0] ilo,
                                              input logic [3:0] ihi);
      return '{mode, sf, m, s, alo, ahi, im, is, in_idx, ilo, ihi};
   endfunction

   // Each mode at its extremes and each register-use special case
   task automatic test_directed();
      sender_idle_on = 1'b0;
      recv_idle_on   = 1'b0;
      send_insn(make_insn(MODE_MUL,   1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1, 2, 3, 4, 5));
      send_insn(make_insn(MODE_MUL,   1, 32'h0001_0000, 32'h0001_0000, 0, 0, 1, 2, 3, 4, 5));
      send_insn(make_insn(MODE_MLA,   1, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000,
                          0, 0, 1, 2, 3, 4));
      send_insn(make_insn(MODE_MLA,   0, 32'h7FFF_FFFF, 32'h0000_0002, 32'h0000_0001,
                          32'hFFFF_FFFF, 6, 7, 8, 9, 15));
      send_insn(make_insn(MODE_UMULL, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1, 2, 15, 3, 4));
      send_insn(make_insn(MODE_UMULL, 1, 0, 32'hFFFF_FFFF, 0, 0, 1, 2, 3, 4, 5));
      send_insn(make_insn(MODE_UMLAL, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 1, 2, 3, 4, 5));
      send_insn(make_insn(MODE_UMLAL, 1, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 1, 1, 3, 4, 5));
      send_insn(make_insn(MODE_SMULL, 1, 32'h8000_0000, 32'h8000_0000, 0, 0, 1, 2, 3, 4, 5));
      send_insn(make_insn(MODE_SMULL, 1, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 1, 2, 3, 4, 5));
      send_insn(make_insn(MODE_SMLAL, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                          32'h7FFF_FFFF, 0, 14, 3, 13, 12));
      send_insn(make_insn(MODE_SMLAL, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 1, 2, 3, 4, 5));
      // Short form register faults, including a PC rn on plain MUL
      send_insn(make_insn(MODE_MUL,   1, 3, 5, 0, 0, 15, 2, 3, 4, 5));
      send_insn(make_insn(MODE_MUL,   1, 3, 5, 0, 0, 1, 15, 3, 4, 5));
      send_insn(make_insn(MODE_MUL,   1, 3, 5, 0, 0, 1, 2, 15, 4, 5));
      send_insn(make_insn(MODE_MLA,   1, 3, 5, 7, 0, 1, 2, 3, 15, 5));
      send_insn(make_insn(MODE_MLA,   1, 3, 5, 7, 0, 6, 2, 3, 6, 5));
      // Long form register faults
      send_insn(make_insn(MODE_UMULL, 1, 3, 5, 0, 0, 1, 2, 3, 4, 15));
      send_insn(make_insn(MODE_SMULL, 1, 3, 5, 0, 0, 4, 2, 3, 4, 5));
      send_insn(make_insn(MODE_UMLAL, 1, 3, 5, 0, 0, 5, 2, 3, 4, 5));
      send_insn(make_insn(MODE_SMLAL, 1, 3, 5, 0, 0, 1, 2, 3, 7, 7));
      // Codes with no operation
      send_insn(make_insn(MODE_RSVD6, 1, 3, 5, 0, 0, 1, 2, 3, 4, 5));
      send_insn(make_insn(MODE_RSVD7, 0, 3, 5, 0, 0, 1, 2, 3, 4, 5));
      wait_drained();
   endtask

   // Random instructions with idle bursts on both channels
   task automatic test_random_idle(input int unsigned count);
      sender_idle_on = 1'b1;
      recv_idle_on   = 1'b1;
      repeat (count) send_insn(rand_insn());
      wait_drained();
   endtask

   // Hold the response side for a long stretch while requests keep coming
   task automatic test_backpressure();
      sender_idle_on = 1'b0;
      recv_idle_on   = 1'b0;
      fork
         begin
            recv_hold <= 1'b1;
            repeat (150) @(posedge clock);
            recv_hold <= 1'b0;
         end
         begin
            repeat (40) send_insn(rand_legal_insn());
         end
      join
      wait_drained();
   endtask

   // Pause the sender until every outstanding result has come back
   task automatic test_drain_pause();
      sender_idle_on = 1'b1;
      recv_idle_on   = 1'b1;
      repeat (20) send_insn(rand_insn());
      wait_drained();
      repeat (20) send_insn(rand_insn());
      wait_drained();
   endtask

   // Full rate on both sides to close the run
   task automatic test_full_rate(input int unsigned count);
      sender_idle_on = 1'b0;
      recv_idle_on   = 1'b0;
      repeat (count) send_insn(rand_insn());
      wait_drained();
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= '0;
      req_set_flags  <= 1'b0;
      req_op_m       <= '0;
      req_op_s       <= '0;
      req_acc_lo     <= '0;
      req_acc_hi     <= '0;
      req_idx_m      <= '0;
      req_idx_s      <= '0;
      req_idx_n      <= '0;
      req_idx_dst_lo <= '0;
      req_idx_dst_hi <= '0;
      rsp_ready      <= 1'b0;
      recv_hold      <= 1'b0;
      recv_gap_left  <= 0;
      sender_idle_on = 1'b0;
      recv_idle_on   = 1'b0;
      error_count        = 0;
      insn_accepted      = 0;
      results_checked    = 0;
      unpredictable_seen = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_idle(1500);
      test_backpressure();
      test_drain_pause();
      test_full_rate(250);
      $display("tb: %0d multiply instructions issued over all six modes and both reserved codes",
               insn_accepted);
      $display("tb: %0d results checked, %0d flagged for register misuse, %0d mismatches",
               results_checked, unpredictable_seen, error_count);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Hard limit on run length
   initial begin
      #3000000;
      $display("tb: timeout with %0d results outstanding", pending_results.size());
      $display("tb: failure");
      $finish;
   end

endmodule
